/* rtl/core/topological_sort_engine_core_macros.svh */
// Assertion macros used by the back end of the topological sort engine RTL.
`ifndef TOPOLOGICAL_SORT_ENGINE_CORE_MACROS_SVH
`define TOPOLOGICAL_SORT_ENGINE_CORE_MACROS_SVH
`ifndef SYNTHESIS
// The consequent must hold in the same cycle as the antecedent.
`define TSE_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("topological sort engine: assertion failed");
// The consequent must hold in the cycle after the antecedent.
`define TSE_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("topological sort engine: assertion failed");
`else
`define TSE_ASSERT_SAME(label, clk, rst, ante, cons)
`define TSE_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

/* rtl/core/tse_pkg.sv */
// Types, constants and helper functions of the topological sort engine.
package tse_pkg;

  localparam int MAX_NODES   = 64;
  localparam int MAX_EDGES   = 256;
  localparam int NODE_W      = 6;
  localparam int CNT_W       = NODE_W + 1;
  localparam int EDGE_AW     = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int ECNT_W      = $clog2(MAX_EDGES + 1);
  localparam int DEG_W       = ECNT_W;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = QPTR_W + 1;

  localparam logic OP_ADD = 1'b0;
  localparam logic OP_RUN = 1'b1;

  typedef struct packed {
    logic              opcode;
    logic [NODE_W-1:0] edge_source;
    logic [NODE_W-1:0] edge_target;
  } item_t;

  typedef struct packed {
    logic [NODE_W-1:0] order_node;
    logic              node_valid;
    logic              last;
    logic              acyclic;
    logic              edges_dropped;
  } result_t;

  // Classified request as it waits between front and back.
  typedef struct packed {
    logic              op;
    logic              bad;
    logic [NODE_W-1:0] src;
    logic [NODE_W-1:0] dst;
  } cmd_t;

  typedef struct packed {
    logic [NODE_W-1:0] src;
    logic [NODE_W-1:0] dst;
  } edge_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

  typedef struct packed {
    logic idle;
  } back_status_t;

  // Node count as the sort sees it: values above the maximum saturate.
  function automatic logic [CNT_W-1:0] eff_nodes(input logic [CNT_W-1:0] cfg);
    logic [CNT_W-1:0] lim;
    lim = CNT_W'(MAX_NODES);
    eff_nodes = (cfg > lim) ? lim : cfg;
  endfunction

endpackage

/* rtl/core/tse_front.sv */
// Front end: takes requests and configuration, range-checks edges, feeds the queue.
module tse_front (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  tse_pkg::item_t             item,
  output logic                       busy,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [tse_pkg::CNT_W-1:0]  cfg_data,
  input  tse_pkg::queue_status_t     q_status,
  input  tse_pkg::back_status_t      back_status,
  output logic                       push,
  output tse_pkg::cmd_t              push_cmd,
  output logic [tse_pkg::CNT_W-1:0]  nodes
);

  logic [tse_pkg::CNT_W-1:0] node_count;
  logic                      stage_valid;
  tse_pkg::cmd_t             stage_cmd;
  tse_pkg::cmd_t             cmd_next;
  logic                      accept;

  assign nodes     = tse_pkg::eff_nodes(node_count);
  assign busy      = stage_valid && q_status.full;
  assign accept    = start && !busy;
  assign push      = stage_valid && !q_status.full;
  assign push_cmd  = stage_cmd;
  assign cfg_ready = !stage_valid && q_status.empty && back_status.idle;

  // An edge naming a node outside the current node count is marked for dropping.
  always_comb begin
    cmd_next.op  = item.opcode;
    cmd_next.src = item.edge_source;
    cmd_next.dst = item.edge_target;
    cmd_next.bad = (item.opcode == tse_pkg::OP_ADD) &&
                   (({1'b0, item.edge_source} >= nodes) ||
                    ({1'b0, item.edge_target} >= nodes));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      node_count  <= tse_pkg::CNT_W'(tse_pkg::MAX_NODES);
      stage_valid <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        node_count <= cfg_data;
      end
      if (accept) begin
        stage_valid <= 1'b1;
      end else if (push) begin
        stage_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      stage_cmd <= cmd_next;
    end
  end

endmodule

/* rtl/core/tse_queue.sv */
// Short request queue between the front end and the sort back end.
module tse_queue (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   push,
  input  tse_pkg::cmd_t          push_cmd,
  input  logic                   pop,
  output tse_pkg::cmd_t          head_cmd,
  output tse_pkg::queue_status_t status
);

  tse_pkg::cmd_t                entries [tse_pkg::QUEUE_DEPTH];
  logic [tse_pkg::QPTR_W-1:0]   wr_ptr;
  logic [tse_pkg::QPTR_W-1:0]   rd_ptr;
  logic [tse_pkg::QCNT_W-1:0]   count;

  assign head_cmd     = entries[rd_ptr];
  assign status.full  = (count == tse_pkg::QCNT_W'(tse_pkg::QUEUE_DEPTH));
  assign status.empty = (count == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + tse_pkg::QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + tse_pkg::QPTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + tse_pkg::QCNT_W'(1);
      end else if (pop && !push) begin
        count <= count - tse_pkg::QCNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

endmodule

/* rtl/core/tse_back.sv */
// Back end: edge store and the sequencer that runs Kahn's sort over it.
`include "topological_sort_engine_core_macros.svh"

module tse_back (
  input  logic                       clk,
  input  logic                       rst,
  input  tse_pkg::queue_status_t     q_status,
  input  tse_pkg::cmd_t              q_cmd,
  output logic                       q_pop,
  input  logic [tse_pkg::CNT_W-1:0]  nodes,
  output tse_pkg::back_status_t      status,
  output logic                       strobe,
  output tse_pkg::result_t           result
);

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_CNT_RD   = 4'd1;
  localparam logic [3:0] S_CNT_CHK  = 4'd2;
  localparam logic [3:0] S_CNT_UPD  = 4'd3;
  localparam logic [3:0] S_SCAN_RD  = 4'd4;
  localparam logic [3:0] S_SCAN_CHK = 4'd5;
  localparam logic [3:0] S_POP_RD   = 4'd6;
  localparam logic [3:0] S_POP_GET  = 4'd7;
  localparam logic [3:0] S_EDG_RD   = 4'd8;
  localparam logic [3:0] S_EDG_CHK  = 4'd9;
  localparam logic [3:0] S_EDG_UPD  = 4'd10;
  localparam logic [3:0] S_FINISH   = 4'd11;

  logic [3:0]                   state;
  logic [tse_pkg::ECNT_W-1:0]   stored_count;
  logic                         drop_flag;
  logic                         run_dropped;
  logic [tse_pkg::ECNT_W-1:0]   e_idx;
  logic [tse_pkg::CNT_W-1:0]    node_i;
  logic [tse_pkg::CNT_W-1:0]    head;
  logic [tse_pkg::CNT_W-1:0]    tail;
  logic [tse_pkg::NODE_W-1:0]   cur_node;
  logic                         pend_valid;
  logic [tse_pkg::NODE_W-1:0]   pend_node;
  logic [tse_pkg::MAX_NODES-1:0] indeg_valid;

  // Edge memory.
  tse_pkg::edge_t               edge_mem [tse_pkg::MAX_EDGES];
  tse_pkg::edge_t               edge_rd_data;
  logic                         edge_we;
  logic                         edge_re;
  logic [tse_pkg::EDGE_AW-1:0]  edge_raddr;

  // In-degree memory; an entry without its valid bit reads as zero.
  logic [tse_pkg::DEG_W-1:0]    indeg_mem [tse_pkg::MAX_NODES];
  logic [tse_pkg::DEG_W-1:0]    indeg_rd_data;
  logic                         indeg_ok;
  logic                         indeg_we;
  logic                         indeg_re;
  logic [tse_pkg::NODE_W-1:0]   indeg_raddr;
  logic [tse_pkg::DEG_W-1:0]    indeg_wdata;
  logic [tse_pkg::DEG_W-1:0]    cur_indeg;

  // Ready queue of the sort.
  logic [tse_pkg::NODE_W-1:0]   fifo_mem [tse_pkg::MAX_NODES];
  logic [tse_pkg::NODE_W-1:0]   fifo_rd_data;
  logic                         fifo_we;
  logic                         fifo_re;
  logic [tse_pkg::NODE_W-1:0]   fifo_wdata;

  logic                         in_range;
  logic                         last_edge;
  logic                         add_drop;

  assign status.idle = (state == S_IDLE);
  assign q_pop       = (state == S_IDLE) && !q_status.empty;
  assign cur_indeg   = indeg_ok ? indeg_rd_data : '0;
  assign in_range    = ({1'b0, edge_rd_data.src} < nodes) &&
                       ({1'b0, edge_rd_data.dst} < nodes);
  assign last_edge   = ((e_idx + tse_pkg::ECNT_W'(1)) == stored_count);
  assign add_drop    = q_cmd.bad ||
                       (stored_count >= tse_pkg::ECNT_W'(tse_pkg::MAX_EDGES));

  always_comb begin
    edge_we     = 1'b0;
    edge_re     = 1'b0;
    edge_raddr  = e_idx[tse_pkg::EDGE_AW-1:0];
    indeg_we    = 1'b0;
    indeg_re    = 1'b0;
    indeg_raddr = edge_rd_data.dst;
    indeg_wdata = cur_indeg + tse_pkg::DEG_W'(1);
    fifo_we     = 1'b0;
    fifo_re     = 1'b0;
    fifo_wdata  = edge_rd_data.dst;
    case (state)
      S_IDLE: begin
        edge_we = q_pop && (q_cmd.op == tse_pkg::OP_ADD) && !add_drop;
      end
      S_CNT_RD, S_EDG_RD: begin
        edge_re = 1'b1;
      end
      S_CNT_CHK: begin
        indeg_re = in_range;
      end
      S_EDG_CHK: begin
        indeg_re = in_range && (edge_rd_data.src == cur_node);
      end
      S_CNT_UPD: begin
        indeg_we = 1'b1;
      end
      S_SCAN_RD: begin
        indeg_re    = (node_i != nodes);
        indeg_raddr = node_i[tse_pkg::NODE_W-1:0];
      end
      S_SCAN_CHK: begin
        fifo_we    = (cur_indeg == '0);
        fifo_wdata = node_i[tse_pkg::NODE_W-1:0];
      end
      S_POP_RD: begin
        fifo_re = (head != tail);
      end
      S_EDG_UPD: begin
        indeg_we    = (cur_indeg != '0);
        indeg_wdata = cur_indeg - tse_pkg::DEG_W'(1);
        fifo_we     = (cur_indeg == tse_pkg::DEG_W'(1));
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (edge_we) begin
      edge_mem[stored_count[tse_pkg::EDGE_AW-1:0]] <= '{src: q_cmd.src, dst: q_cmd.dst};
    end
    if (edge_re) begin
      edge_rd_data <= edge_mem[edge_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (indeg_we) begin
      indeg_mem[edge_rd_data.dst] <= indeg_wdata;
    end
    if (indeg_re) begin
      indeg_rd_data <= indeg_mem[indeg_raddr];
      indeg_ok      <= indeg_valid[indeg_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (fifo_we) begin
      fifo_mem[tail[tse_pkg::NODE_W-1:0]] <= fifo_wdata;
    end
    if (fifo_re) begin
      fifo_rd_data <= fifo_mem[head[tse_pkg::NODE_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      stored_count <= '0;
      drop_flag    <= 1'b0;
      run_dropped  <= 1'b0;
      e_idx        <= '0;
      node_i       <= '0;
      head         <= '0;
      tail         <= '0;
      cur_node     <= '0;
      pend_valid   <= 1'b0;
      pend_node    <= '0;
      indeg_valid  <= '0;
      strobe       <= 1'b0;
    end else begin
      strobe <= 1'b0;
      if (indeg_we) begin
        indeg_valid[edge_rd_data.dst] <= 1'b1;
      end
      if (fifo_we) begin
        tail <= tail + tse_pkg::CNT_W'(1);
      end
      case (state)
        S_IDLE: begin
          if (q_pop) begin
            if (q_cmd.op == tse_pkg::OP_ADD) begin
              if (add_drop) begin
                drop_flag <= 1'b1;
              end else begin
                stored_count <= stored_count + tse_pkg::ECNT_W'(1);
              end
            end else begin
              indeg_valid <= '0;
              run_dropped <= drop_flag;
              e_idx       <= '0;
              node_i      <= '0;
              head        <= '0;
              tail        <= '0;
              pend_valid  <= 1'b0;
              state       <= (stored_count == '0) ? S_SCAN_RD : S_CNT_RD;
            end
          end
        end
        S_CNT_RD: begin
          state <= S_CNT_CHK;
        end
        S_CNT_CHK: begin
          if (in_range) begin
            state <= S_CNT_UPD;
          end else begin
            run_dropped <= 1'b1;
            e_idx       <= e_idx + tse_pkg::ECNT_W'(1);
            state       <= last_edge ? S_SCAN_RD : S_CNT_RD;
          end
        end
        S_CNT_UPD: begin
          e_idx <= e_idx + tse_pkg::ECNT_W'(1);
          state <= last_edge ? S_SCAN_RD : S_CNT_RD;
        end
        S_SCAN_RD: begin
          state <= (node_i == nodes) ? S_POP_RD : S_SCAN_CHK;
        end
        S_SCAN_CHK: begin
          node_i <= node_i + tse_pkg::CNT_W'(1);
          state  <= S_SCAN_RD;
        end
        S_POP_RD: begin
          if (head == tail) begin
            state <= S_FINISH;
          end else begin
            head  <= head + tse_pkg::CNT_W'(1);
            state <= S_POP_GET;
          end
        end
        S_POP_GET: begin
          // The previous node goes out only now, once it is known not to be the last.
          if (pend_valid) begin
            strobe <= 1'b1;
            result <= '{order_node: pend_node, node_valid: 1'b1, last: 1'b0,
                        acyclic: 1'b0, edges_dropped: 1'b0};
          end
          pend_valid <= 1'b1;
          pend_node  <= fifo_rd_data;
          cur_node   <= fifo_rd_data;
          e_idx      <= '0;
          state      <= (stored_count == '0) ? S_POP_RD : S_EDG_RD;
        end
        S_EDG_RD: begin
          state <= S_EDG_CHK;
        end
        S_EDG_CHK: begin
          if (in_range && (edge_rd_data.src == cur_node)) begin
            state <= S_EDG_UPD;
          end else begin
            e_idx <= e_idx + tse_pkg::ECNT_W'(1);
            state <= last_edge ? S_POP_RD : S_EDG_RD;
          end
        end
        S_EDG_UPD: begin
          e_idx <= e_idx + tse_pkg::ECNT_W'(1);
          state <= last_edge ? S_POP_RD : S_EDG_RD;
        end
        S_FINISH: begin
          strobe <= 1'b1;
          result <= '{order_node: pend_valid ? pend_node : '0, node_valid: pend_valid,
                      last: 1'b1, acyclic: (head == nodes),
                      edges_dropped: run_dropped};
          stored_count <= '0;
          drop_flag    <= 1'b0;
          state        <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `TSE_ASSERT_SAME(a_strobe_source, clk, rst, strobe, $past(state) == S_POP_GET || $past(state) == S_FINISH)
  `TSE_ASSERT_NEXT(a_finish_emits_last, clk, rst, state == S_FINISH, strobe && result.last)
  `TSE_ASSERT_SAME(a_head_behind_tail, clk, rst, state != S_IDLE, head <= tail)
  `TSE_ASSERT_SAME(a_tail_bounded, clk, rst, state != S_IDLE, tail <= nodes)
  `TSE_ASSERT_SAME(a_edge_count_bounded, clk, rst, 1'b1, stored_count <= tse_pkg::ECNT_W'(tse_pkg::MAX_EDGES))

endmodule

/* rtl/core/topological_sort_engine_core.sv */
// Top level of the topological sort engine: front end, request queue and sort back end.
//
//   Channel   Signals                        Transfer
//   -------   ----------------------------   -------------------------------------
//   request   start, busy, item              taken when start is high and busy low
//   result    strobe, result                 one cycle per result, cannot be held
//   config    cfg_valid, cfg_ready, cfg_data written when cfg_valid and cfg_ready
//
// Edge requests stream in at one per cycle unless the queue is full: a front register
// and a four-entry queue feed the back end, which, when idle, stores one edge per cycle.
// A run takes the run request in S_IDLE, counts in-degrees over the stored edges
// (S_CNT_RD, S_CNT_CHK, S_CNT_UPD if in range), scans nodes for sources (S_SCAN_RD,
// S_SCAN_CHK), then pops each sorted node (S_POP_RD, S_POP_GET) and walks the edges
// (S_EDG_RD, S_EDG_CHK, S_EDG_UPD if in range and leaving it), then ends in S_FINISH.
// Requests queued behind a run wait until its last result.
// Reset clears the edge count and drop flag and sets node_count to 64; the edge memory
// holds no reset value. The result side has no stall: every result leaves on its strobe.
module topological_sort_engine_core (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  output logic                       busy,
  input  tse_pkg::item_t             item,
  output logic                       strobe,
  output tse_pkg::result_t           result,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [tse_pkg::CNT_W-1:0]  cfg_data
);

  tse_pkg::queue_status_t    q_status;
  tse_pkg::back_status_t     back_status;
  tse_pkg::cmd_t             push_cmd;
  tse_pkg::cmd_t             head_cmd;
  logic                      push;
  logic                      pop;
  logic [tse_pkg::CNT_W-1:0] nodes;

  // The front end checks each edge against the node count in force when it arrives,
  // and holds off configuration until every request has been carried out.
  tse_front u_front (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .item        (item),
    .busy        (busy),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_data    (cfg_data),
    .q_status    (q_status),
    .back_status (back_status),
    .push        (push),
    .push_cmd    (push_cmd),
    .nodes       (nodes)
  );

  // The queue lets requests keep arriving while the back end is tied up in a run.
  tse_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head_cmd (head_cmd),
    .status   (q_status)
  );

  // The back end stores edges and sequences the sort, emitting nodes as they leave
  // the ready queue; the final result also carries the acyclic and dropped flags.
  tse_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_status (q_status),
    .q_cmd    (head_cmd),
    .q_pop    (pop),
    .nodes    (nodes),
    .status   (back_status),
    .strobe   (strobe),
    .result   (result)
  );

endmodule

/* tb/tse_topo_order_checker.sv */
// Checker for the topological sort engine: predicts each sort order and compares results.
`timescale 1ns / 1ps

module tse_topo_order_checker (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic                      busy,
  input  tse_pkg::item_t            item,
  input  logic                      strobe,
  input  tse_pkg::result_t          result,
  input  logic                      cfg_valid,
  input  logic                      cfg_ready,
  input  logic [tse_pkg::CNT_W-1:0] cfg_data,
  output int                        mismatches,
  output int                        open_results
);
  import tse_pkg::*;

  // Mirror of the block's edge list and node count.
  logic [NODE_W-1:0] edge_src_mem [MAX_EDGES];
  logic [NODE_W-1:0] edge_dst_mem [MAX_EDGES];
  int unsigned       edge_total;
  bit                drop_seen;
  logic [CNT_W-1:0]  node_cfg;

  result_t expected_order[$];

  // Kahn's sort over the mirrored edge list; queues the results of one run.
  function automatic void predict_kahn_order();
    int unsigned       n;
    int unsigned       head;
    int                indeg [MAX_NODES];
    logic [NODE_W-1:0] ready_nodes[$];
    logic [NODE_W-1:0] u;
    logic [NODE_W-1:0] v;
    bit                dropped;
    result_t           r;
    result_t           run_out[$];
    n = (node_cfg > CNT_W'(MAX_NODES)) ? MAX_NODES : node_cfg;
    dropped = drop_seen;
    for (int i = 0; i < MAX_NODES; i++) indeg[i] = 0;
    // Edges that name a node beyond the current count are ignored and count as dropped.
    for (int e = 0; e < edge_total; e++) begin
      if (edge_src_mem[e] < n && edge_dst_mem[e] < n) indeg[edge_dst_mem[e]]++;
      else dropped = 1'b1;
    end
    for (int i = 0; i < n; i++)
      if (indeg[i] == 0) ready_nodes.insert(ready_nodes.size(), NODE_W'(i));
    head = 0;
    while (head < ready_nodes.size()) begin
      u = ready_nodes[head];
      head++;
      r = '0;
      r.order_node = u;
      r.node_valid = 1'b1;
      run_out.insert(run_out.size(), r);
      for (int e = 0; e < edge_total; e++) begin
        if (edge_src_mem[e] == u && edge_src_mem[e] < n && edge_dst_mem[e] < n) begin
          v = edge_dst_mem[e];
          if (indeg[v] > 0) begin
            indeg[v]--;
            if (indeg[v] == 0) ready_nodes.insert(ready_nodes.size(), v);
          end
        end
      end
    end
    if (run_out.size() == 0) begin
      r = '0;
      r.last = 1'b1;
      r.acyclic = (n == 0);
      r.edges_dropped = dropped;
      run_out.insert(run_out.size(), r);
    end else begin
      r = run_out[run_out.size()-1];
      r.last = 1'b1;
      r.acyclic = (head == n);
      r.edges_dropped = dropped;
      run_out[run_out.size()-1] = r;
    end
    foreach (run_out[k]) expected_order.insert(expected_order.size(), run_out[k]);
    edge_total = 0;
    drop_seen = 1'b0;
  endfunction

  always @(posedge clk) begin
    result_t     want;
    int unsigned n;
    if (rst) begin
      edge_total = 0;
      drop_seen = 1'b0;
      node_cfg = CNT_W'(MAX_NODES);
      expected_order.delete();
      mismatches = 0;
    end else begin
      if (cfg_valid && cfg_ready) node_cfg = cfg_data;
      if (start && !busy) begin
        if (item.opcode == OP_RUN) begin
          predict_kahn_order();
        end else begin
          n = (node_cfg > CNT_W'(MAX_NODES)) ? MAX_NODES : node_cfg;
          if (edge_total >= MAX_EDGES || item.edge_source >= n || item.edge_target >= n) begin
            drop_seen = 1'b1;
          end else begin
            edge_src_mem[edge_total] = item.edge_source;
            edge_dst_mem[edge_total] = item.edge_target;
            edge_total++;
          end
        end
      end
      if (strobe) begin
        if (expected_order.size() == 0) begin
          if (mismatches < 10)
            $display("%0t: result with none expected: node %0d valid %0b last %0b acyc %0b drop %0b",
                     $realtime, result.order_node, result.node_valid, result.last,
                     result.acyclic, result.edges_dropped);
          mismatches++;
        end else begin
          want = expected_order.pop_front();
          if (result.order_node !== want.order_node || result.node_valid !== want.node_valid ||
              result.last !== want.last || result.acyclic !== want.acyclic ||
              result.edges_dropped !== want.edges_dropped) begin
            if (mismatches < 10)
              $display("%0t: mismatch: got node %0d valid %0b last %0b acyc %0b drop %0b, %s",
                       $realtime, result.order_node, result.node_valid, result.last,
                       result.acyclic, result.edges_dropped,
                       $sformatf("want node %0d valid %0b last %0b acyc %0b drop %0b",
                                 want.order_node, want.node_valid, want.last,
                                 want.acyclic, want.edges_dropped));
            mismatches++;
          end
        end
      end
    end
    open_results = expected_order.size();
  end

endmodule

/* tb/tb_topological_sort_engine_core.sv */
// Testbench top for the topological sort engine: stimulus, reset, clock and verdict.
`timescale 1ns / 1ps

module tb_topological_sort_engine_core;
  import tse_pkg::*;

  localparam int    RANDOM_ITEMS = 440;
  // Cycles allowed after the last result for queued edge loads to reach the edge memory.
  localparam int    DRAIN_CYCLES = 40;
  localparam longint TIMEOUT_NS  = 40_000_000;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             start = 1'b0;
  item_t            item = '0;
  logic             cfg_valid = 1'b0;
  logic [CNT_W-1:0] cfg_data = '0;
  logic             busy;
  logic             strobe;
  result_t          result;
  logic             cfg_ready;
  int               mismatches;
  int               open_results;

  // Stimulus bookkeeping: requests accepted so far, the node count last written, and the
  // window of requests during which the sender never pauses.
  int               requests_sent = 0;
  int               steady_from = 0;
  int               node_setting = MAX_NODES;

  always #4 clk = ~clk;

  topological_sort_engine_core u_top (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .item      (item),
    .strobe    (strobe),
    .result    (result),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  tse_topo_order_checker u_checker (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .item         (item),
    .strobe       (strobe),
    .result       (result),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data),
    .mismatches   (mismatches),
    .open_results (open_results)
  );

  // Presents one request and holds it until the block takes it. Start stays high afterwards,
  // so back-to-back requests keep it high; pauses lower it before the next request goes out.
  task automatic send_request(input logic op, input logic [NODE_W-1:0] src,
                              input logic [NODE_W-1:0] dst);
    if (requests_sent < steady_from || requests_sent >= steady_from + 90) begin
      while ($urandom_range(0, 99) < 36) begin
        start <= 1'b0;
        @(posedge clk);
      end
    end
    start <= 1'b1;
    item <= '{opcode: op, edge_source: src, edge_target: dst};
    do @(posedge clk); while (busy);
    requests_sent++;
  endtask

  task automatic add_edge(input int src, input int dst);
    send_request(OP_ADD, NODE_W'(src), NODE_W'(dst));
  endtask

  // The edge fields of a run request are don't-care, so they carry random bits.
  task automatic run_sort();
    send_request(OP_RUN, NODE_W'($urandom_range(0, 63)), NODE_W'($urandom_range(0, 63)));
  endtask

  // Waits until every predicted result has arrived, then lets pending edge loads finish.
  task automatic settle();
    start <= 1'b0;
    @(posedge clk);
    while (open_results != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // The node count is only ever changed while the block is idle.
  task automatic write_node_count(input int value);
    settle();
    repeat ($urandom_range(0, 2)) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= CNT_W'(value);
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    node_setting = value;
  endtask

  // Node counts for the random part lean toward small graphs but keep the extremes,
  // including values above the maximum that must saturate.
  function automatic int pick_node_count();
    case ($urandom_range(0, 9))
      0:       pick_node_count = 0;
      1:       pick_node_count = 1;
      2:       pick_node_count = MAX_NODES;
      3:       pick_node_count = 127;
      4:       pick_node_count = $urandom_range(MAX_NODES + 1, 127);
      5, 6:    pick_node_count = $urandom_range(1, MAX_NODES);
      default: pick_node_count = $urandom_range(2, 12);
    endcase
  endfunction

  initial begin
    int  n_eff;
    int  edge_num;
    int  dag_share;
    int  a;
    int  b;
    bit  filled;
    filled = 1'b0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part. An empty graph at the reset node count lists every node in order.
    run_sort();
    // Extreme node indexes in a small chain.
    add_edge(63, 0);
    add_edge(0, 62);
    add_edge(62, 1);
    run_sort();
    // A self loop keeps its node from ever becoming ready, so the graph reads as cyclic.
    add_edge(5, 5);
    add_edge(1, 2);
    run_sort();
    // With zero nodes every edge is out of range and the run reports an empty acyclic sort.
    write_node_count(0);
    add_edge(0, 0);
    run_sort();
    // A count above the maximum behaves as the maximum.
    write_node_count(127);
    add_edge(10, 63);
    run_sort();
    // Every node on a cycle: nothing is processed. The edge from node 2 is out of range at load.
    write_node_count(2);
    add_edge(0, 1);
    add_edge(1, 0);
    add_edge(2, 0);
    run_sort();
    write_node_count(1);
    run_sort();
    // Shrinking the node count after loading makes a stored edge fall out of range.
    write_node_count(MAX_NODES);
    add_edge(40, 3);
    add_edge(1, 2);
    write_node_count(10);
    run_sort();

    // Random part: load a graph, sometimes reconfigure, then sort it.
    steady_from = requests_sent + $urandom_range(40, 250);
    while (requests_sent < RANDOM_ITEMS + 20) begin
      if (!filled && requests_sent > 150) begin
        // Overfill the edge list on a tiny graph so the run stays short.
        write_node_count($urandom_range(1, 3));
        repeat (MAX_EDGES + $urandom_range(1, 4))
          add_edge($urandom_range(0, node_setting - 1), $urandom_range(0, node_setting - 1));
        run_sort();
        filled = 1'b1;
        continue;
      end
      if ($urandom_range(0, 2) == 0) write_node_count(pick_node_count());
      n_eff = (node_setting > MAX_NODES) ? MAX_NODES : node_setting;
      edge_num = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(0, 12);
      // Most graphs are built mainly from short forward hops so the sort runs deep; the rest
      // are arbitrary in-range graphs, with some out-of-range noise mixed into both.
      dag_share = ($urandom_range(0, 99) < 60) ? 90 : 0;
      repeat (edge_num) begin
        if (n_eff >= 2 && $urandom_range(0, 99) < dag_share) begin
          a = $urandom_range(0, n_eff - 2);
          b = $urandom_range(a + 1, (a + 4 < n_eff - 1) ? a + 4 : n_eff - 1);
          add_edge(a, b);
        end else if (n_eff >= 1 && $urandom_range(0, 99) < 85) begin
          add_edge($urandom_range(0, n_eff - 1), $urandom_range(0, n_eff - 1));
        end else begin
          add_edge($urandom_range(0, 63), $urandom_range(0, 63));
        end
      end
      if ($urandom_range(0, 7) == 0) write_node_count(pick_node_count());
      run_sort();
    end

    settle();
    if (mismatches == 0 && open_results == 0) begin
      $display("[topological_sort_engine_core] OK");
    end else begin
      $display("[topological_sort_engine_core] ERROR");
    end
    $finish;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("[topological_sort_engine_core] ERROR");
    $finish;
  end

endmodule
